/* hdl/adbd_pkg.sv */
// Shared types and constants for the ADPCM block decoder.
// Used by the front, queue, back and top-level modules; depends on nothing.
package adbd_pkg;

  localparam logic [1:0] CLS_HDR   = 2'd0;
  localparam logic [1:0] CLS_FLAGS = 2'd1;
  localparam logic [1:0] CLS_DATA  = 2'd2;

  localparam logic [3:0] POS_HDR   = 4'd0;
  localparam logic [3:0] POS_FLAGS = 4'd1;
  localparam logic [2:0] FILTER_MAX = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    logic               loop_start;
    logic               loop_end;
    logic               loop_repeat;
    logic               last;
  } out_t;

  typedef struct packed {
    logic [1:0] cls;
    logic       restart;
    logic [7:0] data_byte;
    logic [2:0] filter;
    logic [3:0] shift;
  } entry_t;

  typedef struct packed {
    logic signed [7:0] c0;
    logic signed [7:0] c1;
  } coef_t;

  function automatic coef_t coef_lookup(input logic [2:0] filter);
    coef_t c;
    case (filter)
      3'd1:    c = '{c0: 8'sd60,  c1: 8'sd0};
      3'd2:    c = '{c0: 8'sd115, c1: -8'sd52};
      3'd3:    c = '{c0: 8'sd98,  c1: -8'sd55};
      3'd4:    c = '{c0: 8'sd122, c1: -8'sd60};
      default: c = '{c0: 8'sd0,   c1: 8'sd0};
    endcase
    return c;
  endfunction

endpackage

/* hdl/adpcm_block_decoder_unit.sv */
// Top level of the ADPCM block decoder: front end, entry queue and back end.
// Depends on adbd_pkg, adbd_front, adbd_queue and adbd_back.
//
//   Channel  Direction  Handshake          Beat
//   in_      input      in_valid/in_ready  in_t: data_byte, restart
//   out_     output     out_valid/out_ready out_t: kind, sample, flags, last
//   cfg_     input      cfg_we             cfg_wdata: output enable
//
// A data byte yields two samples, decoded one after the other, because each
// sample feeds the prediction history of the next. A flags byte yields one result and a header byte none.
// Reset is synchronous on rst_n and clears position, header fields, history
// and the queue; output enable resets to one. The queue lets the front accept
// bytes while the back end waits on out_ready.
module adpcm_block_decoder_unit import adbd_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  logic   push_valid, push_ready;
  entry_t push_entry;
  logic   pop_valid, pop_ready;
  entry_t pop_entry;

  adbd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  adbd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  adbd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* hdl/adbd_front.sv */
// Front end: accepts input beats, tracks the block position and header fields,
// and classifies each byte into a queue entry. Depends on adbd_pkg.
module adbd_front import adbd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  in_t    in_data,
  output logic   push_valid,
  input  logic   push_ready,
  output entry_t push_entry
);

  logic [3:0] pos_r, pos_nxt;
  logic [2:0] filter_r, filter_nxt;
  logic [3:0] shift_r, shift_nxt;
  logic [3:0] pos_eff;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;
  assign pos_eff    = in_data.restart ? POS_HDR : pos_r;

  always_comb begin
    pos_nxt    = pos_r;
    filter_nxt = filter_r;
    shift_nxt  = shift_r;
    if (accept) begin
      pos_nxt = pos_eff + 4'd1;
      if (pos_eff == POS_HDR) begin
        filter_nxt = (in_data.data_byte[7:4] > {1'b0, FILTER_MAX}) ? 3'd0
                                                                   : in_data.data_byte[6:4];
        shift_nxt  = in_data.data_byte[3:0];
      end
    end
  end

  always_comb begin
    push_entry.restart   = in_data.restart;
    push_entry.data_byte = in_data.data_byte;
    push_entry.filter    = filter_r;
    push_entry.shift     = shift_r;
    if (pos_eff == POS_HDR) begin
      push_entry.cls = CLS_HDR;
    end else if (pos_eff == POS_FLAGS) begin
      push_entry.cls = CLS_FLAGS;
    end else begin
      push_entry.cls = CLS_DATA;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      filter_r <= '0;
      shift_r  <= '0;
    end else begin
      pos_r    <= pos_nxt;
      filter_r <= filter_nxt;
      shift_r  <= shift_nxt;
    end
  end

endmodule

/* hdl/adbd_queue.sv */
// Short first-in first-out queue of classified entries between front and back.
// Depends on adbd_pkg.
module adbd_queue import adbd_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push_valid,
  output logic   push_ready,
  input  entry_t push_entry,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_entry
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          mem [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

/* hdl/adbd_back.sv */
// Back end: decodes queued entries into flag and sample results, at most one
// result per cycle while out_ready does not stall it, holding the prediction history. Depends on adbd_pkg.
module adbd_back import adbd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   cfg_we,
  input  logic   cfg_wdata,
  input  logic   pop_valid,
  output logic   pop_ready,
  input  entry_t pop_entry,
  output logic   out_valid,
  input  logic   out_ready,
  output out_t   out_data
);

  logic               enable_r;
  logic               busy_r, busy_nxt;
  logic               phase_r, phase_nxt;
  entry_t             entry_r;
  logic signed [15:0] h1_r, h1_nxt;
  logic signed [15:0] h2_r, h2_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r, out_data_nxt;

  logic               can_out, is_data, is_hdr, done, load, pop;
  logic [3:0]         nibble;
  logic signed [15:0] base, shifted;
  coef_t              coef;
  logic signed [23:0] p1, p2;
  logic signed [19:0] sum;
  logic signed [15:0] clamped;

  assign can_out = !out_valid_r || out_ready;
  assign is_data = (entry_r.cls == CLS_DATA);
  assign is_hdr  = (entry_r.cls == CLS_HDR);
  assign done    = busy_r && (is_hdr || (can_out && (!is_data || phase_r)));
  assign load    = busy_r && can_out && !is_hdr;
  assign pop_ready = !busy_r || done;
  assign pop     = pop_valid && pop_ready;

  assign nibble  = phase_r ? entry_r.data_byte[7:4] : entry_r.data_byte[3:0];
  assign base    = $signed({nibble, 12'd0});
  assign shifted = base >>> entry_r.shift;
  assign coef    = coef_lookup(entry_r.filter);
  assign p1      = h1_r * coef.c0;
  assign p2      = h2_r * coef.c1;
  assign sum     = $signed({{4{shifted[15]}}, shifted})
                 + $signed({{2{p1[23]}}, p1[23:6]})
                 + $signed({{2{p2[23]}}, p2[23:6]});

  always_comb begin
    if (sum > 20'sd32767) begin
      clamped = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      clamped = 16'sh8000;
    end else begin
      clamped = sum[15:0];
    end
  end

  always_comb begin
    h1_nxt = h1_r;
    h2_nxt = h2_r;
    if (pop && pop_entry.restart) begin
      h1_nxt = '0;
      h2_nxt = '0;
    end else if (load && is_data) begin
      h2_nxt = h1_r;
      h1_nxt = clamped;
    end
  end

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    if (pop) begin
      busy_nxt  = 1'b1;
      phase_nxt = 1'b0;
    end else if (done) begin
      busy_nxt  = 1'b0;
      phase_nxt = 1'b0;
    end else if (load && is_data) begin
      phase_nxt = 1'b1;
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    if (load) begin
      if (is_data) begin
        out_data_nxt.kind        = 1'b0;
        out_data_nxt.sample      = enable_r ? clamped : 16'sd0;
        out_data_nxt.loop_start  = 1'b0;
        out_data_nxt.loop_end    = 1'b0;
        out_data_nxt.loop_repeat = 1'b0;
        out_data_nxt.last        = phase_r;
      end else begin
        out_data_nxt.kind        = 1'b1;
        out_data_nxt.sample      = 16'sd0;
        out_data_nxt.loop_start  = entry_r.data_byte[2];
        out_data_nxt.loop_end    = entry_r.data_byte[0];
        out_data_nxt.loop_repeat = entry_r.data_byte[1];
        out_data_nxt.last        = 1'b1;
      end
    end
  end

  assign out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      entry_r <= pop_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      busy_r      <= 1'b0;
      phase_r     <= 1'b0;
      h1_r        <= '0;
      h2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        enable_r <= cfg_wdata;
      end
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      h1_r        <= h1_nxt;
      h2_r        <= h2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_phase_only_data: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r |-> (busy_r && entry_r.cls == CLS_DATA))
    else $error("second nibble phase outside a data entry");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && pop_entry.restart) |=> (h1_r == 16'sd0 && h2_r == 16'sd0))
    else $error("history not cleared on restart");

  a_flags_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind) |-> (out_data_r.last && out_data_r.sample == 16'sd0))
    else $error("flags beat malformed");

  a_no_load_while_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !load)
    else $error("result overwritten before it was taken");

endmodule
